### rtl/core/periodic_timer_slot_scheduler_core_defines.svh
// Assertion macros shared by the timer slot scheduler RTL.
`ifndef PERIODIC_TIMER_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TIMER_SLOT_SCHEDULER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PTSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define PTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ptss_pkg.sv
// Types and constants of the timer slot scheduler.
package ptss_pkg;

    localparam logic [2:0] KIND_SCAN   = 3'd0;
    localparam logic [2:0] KIND_CREATE = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_REPEAT = 3'd4;
    localparam logic [2:0] KIND_PERIOD = 3'd5;
    localparam logic [2:0] KIND_ACTION = 3'd6;
    localparam logic [2:0] KIND_QUERY  = 3'd7;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_UNUSED  = 2'd2;

    // results reported per scan; later fires still take effect
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic signed [15:0] REPEAT_FOREVER = -16'sd1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         slot;
        logic [31:0]        now_ms;
        logic [31:0]        period_ms;
        logic signed [15:0] repeat_req;
        logic               pause_flag;
        logic               action_on;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         result_slot;
        logic               fired;
        logic [1:0]         status;
        logic signed [15:0] repeat_left;
        logic [31:0]        period_out;
        logic               paused_out;
        logic               last;
    } out_item_t;

    // one slot's state as held in the slot RAM
    typedef struct packed {
        logic [31:0]        period;
        logic signed [15:0] repeat_cnt;
        logic               paused;
        logic               armed;
        logic [31:0]        phase;
        logic [31:0]        last_fire;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/periodic_timer_slot_scheduler_core.sv
// Timer slot scheduler: slot table in RAM, command handling and scan walk.
// A table of SLOTS timer slots. Each input transaction carries the current
// millisecond time and either runs a scan or creates, deletes, pauses,
// re-counts, re-periods, arms or queries one slot. Non-scan commands return
// exactly one result, built in ST_OP and moved to the output register once
// that is free. A scan walks the slot RAM one slot per cycle, unless a fire
// waits on a stalled output, with read-modify-write; fires come out in
// ascending slot order, at most 16 per scan, and the final one has last
// set. One fire is held back until the next one (or the end of the walk) is
// known so the last flag can be set. A scan with nothing due returns no
// result. A new transaction is taken only once the previous one has been
// fully worked off; the output register lets that happen while the final
// result still waits to be taken.
`include "periodic_timer_slot_scheduler_core_defines.svh"

module periodic_timer_slot_scheduler_core #(
    parameter int unsigned SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptss_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ptss_pkg::out_item_t out_item
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_OP    = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    ptss_pkg::in_item_t   req_reg, req_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic                 any_reg, any_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [ptss_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    ptss_pkg::out_item_t  pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    ptss_pkg::out_item_t  out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 ram_we;
    logic [SW-1:0]        ram_waddr, ram_raddr;
    ptss_pkg::entry_t     ram_wdata, ram_rdata;

    logic                 out_free;
    logic                 scan_stall;
    logic [SW-1:0]        slot_idx;
    logic                 slot_ok;
    logic                 free_found;
    logic [SW-1:0]        free_idx;
    logic [31:0]          elapsed;
    ptss_pkg::entry_t     upd;
    ptss_pkg::out_item_t  res;

    ptss_ram #(
        .WIDTH (ptss_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign slot_idx = SW'(req_reg.slot);
    assign slot_ok  = (32'(req_reg.slot) < SLOTS) && used_reg[slot_idx];
    assign elapsed  = req_reg.now_ms - ram_rdata.last_fire;

    // lowest free slot for create
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        any_next        = any_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;
        scan_stall      = 1'b0;
        upd             = ram_rdata;
        res             = '0;
        res.status      = ptss_pkg::STATUS_OK;
        res.last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = (in_item.kind == ptss_pkg::KIND_SCAN) ? '0 : SW'(in_item.slot);
                if (in_valid)
                begin
                    req_next = in_item;
                    idx_next = '0;
                    cnt_next = '0;
                    if (in_item.kind != ptss_pkg::KIND_SCAN)
                    begin
                        state_next = ST_OP;
                    end
                    else if (any_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                res.last        = 1'b0;
                res.fired       = 1'b1;
                res.result_slot = 4'(idx_reg);
                if (used_reg[idx_reg])
                begin
                    if (ram_rdata.repeat_cnt == 16'sd0)
                    begin
                        used_next[idx_reg] = 1'b0;
                    end
                    else if (!ram_rdata.paused && elapsed >= ram_rdata.period
                             && ram_rdata.armed)
                    begin
                        if (!ram_rdata.repeat_cnt[15])
                        begin
                            upd.repeat_cnt = ram_rdata.repeat_cnt - 16'sd1;
                        end
                        upd.last_fire   = req_reg.now_ms;
                        res.repeat_left = upd.repeat_cnt;
                        if (cnt_reg < ptss_pkg::CNT_W'(ptss_pkg::MAX_RESULTS))
                        begin
                            scan_stall = pend_valid_reg && !out_free;
                            if (!scan_stall)
                            begin
                                cnt_next        = cnt_reg + 1'b1;
                                pend_next       = res;
                                pend_valid_next = 1'b1;
                                if (pend_valid_reg)
                                begin
                                    out_next       = pend_reg;
                                    out_valid_next = 1'b1;
                                end
                            end
                        end
                        ram_we    = !scan_stall;
                        ram_wdata = upd;
                    end
                end
                if (!scan_stall)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_raddr = idx_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_OP:
            begin
                ram_raddr       = slot_idx;
                ram_waddr       = slot_idx;
                res.result_slot = req_reg.slot;
                if (req_reg.kind == ptss_pkg::KIND_CREATE)
                begin
                    ram_waddr = free_idx;
                    if (free_found)
                    begin
                        upd.period      = req_reg.period_ms;
                        upd.repeat_cnt  = ptss_pkg::REPEAT_FOREVER;
                        upd.paused      = 1'b0;
                        upd.armed       = 1'b1;
                        upd.phase       = '0;
                        upd.last_fire   = req_reg.now_ms;
                        res.result_slot = 4'(free_idx);
                        res.repeat_left = ptss_pkg::REPEAT_FOREVER;
                    end
                    else
                    begin
                        res.result_slot = '0;
                        res.status      = ptss_pkg::STATUS_NO_FREE;
                    end
                end
                else if (!slot_ok)
                begin
                    res.status = ptss_pkg::STATUS_UNUSED;
                end
                else
                begin
                    case (req_reg.kind)
                        ptss_pkg::KIND_DELETE:
                        begin
                            upd.phase      = (elapsed > ram_rdata.period) ? '0 : elapsed;
                            upd.paused     = 1'b1;
                            upd.repeat_cnt = '0;
                            upd.armed      = 1'b0;
                        end
                        ptss_pkg::KIND_PAUSE:
                        begin
                            if (req_reg.pause_flag)
                            begin
                                upd.phase = (elapsed > ram_rdata.period) ? '0 : elapsed;
                            end
                            else
                            begin
                                upd.last_fire = req_reg.now_ms - ram_rdata.phase;
                                upd.phase     = '0;
                            end
                            upd.paused = req_reg.pause_flag;
                        end
                        ptss_pkg::KIND_REPEAT: upd.repeat_cnt = req_reg.repeat_req;
                        ptss_pkg::KIND_PERIOD: upd.period     = req_reg.period_ms;
                        ptss_pkg::KIND_ACTION: upd.armed      = req_reg.action_on;
                        ptss_pkg::KIND_QUERY:
                        begin
                            res.period_out = ram_rdata.period;
                            res.paused_out = ram_rdata.paused;
                        end
                        default: ;
                    endcase
                    res.repeat_left = upd.repeat_cnt;
                end
                ram_wdata = upd;
                if (out_free)
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (req_reg.kind == ptss_pkg::KIND_CREATE)
                    begin
                        if (free_found)
                        begin
                            ram_we              = 1'b1;
                            used_next[free_idx] = 1'b1;
                            any_next            = 1'b1;
                        end
                    end
                    else
                    begin
                        ram_we = slot_ok && (req_reg.kind != ptss_pkg::KIND_QUERY);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            any_reg        <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            any_reg        <= any_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    `PTSS_ASSERT(a_pend_in_scan, !pend_valid_reg || state_reg == ST_SCAN || state_reg == ST_FLUSH, "held fire outside scan")
    `PTSS_ASSERT(a_cnt_bound, cnt_reg <= ptss_pkg::CNT_W'(ptss_pkg::MAX_RESULTS), "scan result count overflow")
    `PTSS_ASSERT(a_we_state, !ram_we || state_reg == ST_SCAN || state_reg == ST_OP, "slot RAM written while idle")
    `PTSS_ASSERT(a_scan_we_used, !(ram_we && state_reg == ST_SCAN) || used_reg[idx_reg], "scan wrote a free slot")
    `PTSS_ASSERT_NEXT(a_stall_hold, scan_stall, idx_reg == $past(idx_reg) && state_reg == ST_SCAN, "scan advanced while stalled")

endmodule

### rtl/core/ptss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
